// ===== src/tcpq_pkg.sv =====
// shared types and constants of the three-class priority queue
package tcpq_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int TAG_W       = 16;
    localparam int ROOM_W      = 8;
    localparam int AGE_W       = 7;
    localparam int ENTRY_W     = TAG_W + ROOM_W;

    localparam logic [AGE_W-1:0] SENIOR_AGE_RESET = 7'd60;

    // request codes
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_SERVE   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_SERVED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    // class codes
    localparam logic [1:0] CLASS_URGENT   = 2'd0;
    localparam logic [1:0] CLASS_PRIORITY = 2'd1;
    localparam logic [1:0] CLASS_NORMAL   = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [TAG_W-1:0]  patient_tag;
        logic [AGE_W-1:0]  age;
        logic              is_pregnant;
        logic              is_emergency;
        logic [ROOM_W-1:0] room;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        queue_class;
        logic [TAG_W-1:0]  out_tag;
        logic [ROOM_W-1:0] out_room;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        logic              is_serve;
        logic [1:0]        cls;
        logic [TAG_W-1:0]  tag;
        logic [ROOM_W-1:0] room;
    } t_cmd;

    // command queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_cmdq_status;

endpackage

// ===== src/three_class_priority_queue_core.sv =====
// top level of the three-class strict-priority queue
//
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready   o_out_data (t_out_item)
// cfg       input      i_cfg_wr_en                 i_cfg_wr_data (senior age limit)
//
// enqueue and serve-with-nothing-waiting are answered straight from S_IDLE,
// a serve that pops passes through S_READ: the ring store has a registered read port
// a two-entry command queue lets intake continue while the back end works
// a stalled output holds the back end; intake stops once the queue is full
// synchronous active-low reset empties all rings and the command queue
module three_class_priority_queue_core
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [AGE_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    t_cmdq_status cmdq_status;
    logic         cmd_push;
    logic         cmd_pop;
    t_cmd         front_cmd;
    t_cmd         back_cmd;

    // request intake and classification
    tcpq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_cmdq_status (cmdq_status),
        .o_cmd_push    (cmd_push),
        .o_cmd         (front_cmd)
    );

    // decoupling queue
    tcpq_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_cmd    (front_cmd),
        .o_status (cmdq_status),
        .i_pop    (cmd_pop),
        .o_cmd    (back_cmd)
    );

    // ring storage and scheduling
    tcpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmdq_status.empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/tcpq_ram.sv =====
// generic single-write, single-read ram with registered read
module tcpq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/tcpq_front.sv =====
// front end: config register, request intake and class decision
module tcpq_front
    import tcpq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [AGE_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    input  t_cmdq_status     i_cmdq_status,
    output logic             o_cmd_push,
    output t_cmd             o_cmd
);

    logic [AGE_W-1:0] r_senior_age;
    logic [1:0]       cls;

    // senior age limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_senior_age <= SENIOR_AGE_RESET;
        end else if (i_cfg_wr_en) begin
            r_senior_age <= i_cfg_wr_data;
        end
    end

    // priority test wins over emergency
    always_comb begin
        if (i_in_data.age >= r_senior_age || i_in_data.is_pregnant) begin
            cls = CLASS_PRIORITY;
        end else if (i_in_data.is_emergency) begin
            cls = CLASS_URGENT;
        end else begin
            cls = CLASS_NORMAL;
        end
    end

    // hand the classified request to the command queue
    assign o_in_ready      = !i_cmdq_status.full;
    assign o_cmd_push      = i_in_valid && o_in_ready;
    assign o_cmd.is_serve  = (i_in_data.req_type == REQ_SERVE);
    assign o_cmd.cls       = cls;
    assign o_cmd.tag       = i_in_data.patient_tag;
    assign o_cmd.room      = i_in_data.room;

endmodule

// ===== src/tcpq_cmdq.sv =====
// two-entry command queue between front and back
module tcpq_cmdq
    import tcpq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_cmd         i_cmd,
    output t_cmdq_status o_status,
    input  logic         i_pop,
    output t_cmd         o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_cmd          = r_slot[r_rd_ptr];

endmodule

// ===== src/tcpq_back.sv =====
// back end: three ring buffers, strict-priority pop and result register
module tcpq_back
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [PTR_W-1:0] r_head  [NUM_CLASSES];
    logic [PTR_W-1:0] r_tail  [NUM_CLASSES];
    logic [CNT_W-1:0] r_count [NUM_CLASSES];
    logic [PTR_W-1:0] n_head  [NUM_CLASSES];
    logic [PTR_W-1:0] n_tail  [NUM_CLASSES];
    logic [CNT_W-1:0] n_count [NUM_CLASSES];

    logic [NUM_CLASSES-1:0] full;
    logic [NUM_CLASSES-1:0] nonempty;
    logic [NUM_CLASSES-1:0] push_en;
    logic [NUM_CLASSES-1:0] pop_en;
    logic [ENTRY_W-1:0]     rd_data [NUM_CLASSES];

    logic [1:0]         r_rd_cls;
    logic [1:0]         n_rd_cls;
    logic [1:0]         sel_cls;
    logic               enq_full;
    logic [ENTRY_W-1:0] sel_data;
    logic               out_free;
    logic               take;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic               load_out;

    // per-class occupancy flags
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            full[c]     = (r_count[c] == CNT_W'(QUEUE_DEPTH));
            nonempty[c] = (r_count[c] != '0);
        end
    end

    // strict priority pick for serve
    always_comb begin
        if (nonempty[0]) begin
            sel_cls = CLASS_URGENT;
        end else if (nonempty[1]) begin
            sel_cls = CLASS_PRIORITY;
        end else begin
            sel_cls = CLASS_NORMAL;
        end
    end

    // full flag of the class an enqueue targets
    always_comb begin
        enq_full = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (i_cmd.cls == 2'(c) && full[c]) begin
                enq_full = 1'b1;
            end
        end
    end

    // read data of the class being served
    always_comb begin
        sel_data = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (r_rd_cls == 2'(c)) begin
                sel_data = rd_data[c];
            end
        end
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign take      = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_pop = take;

    // push and pop enables
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            push_en[c] = take && !i_cmd.is_serve && i_cmd.cls == 2'(c) && !full[c];
            pop_en[c]  = take && i_cmd.is_serve && (nonempty != '0) && sel_cls == 2'(c);
        end
    end

    // ring pointer and count update
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            n_head[c]  = r_head[c];
            n_tail[c]  = r_tail[c];
            n_count[c] = r_count[c];
            if (push_en[c]) begin
                n_tail[c]  = (r_tail[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_tail[c] + 1'b1;
                n_count[c] = r_count[c] + 1'b1;
            end
            if (pop_en[c]) begin
                n_head[c]  = (r_head[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_head[c] + 1'b1;
                n_count[c] = r_count[c] - 1'b1;
            end
        end
    end

    // sequencer and result formation
    always_comb begin
        n_state  = r_state;
        n_rd_cls = r_rd_cls;
        n_out    = r_out;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (!i_cmd.is_serve) begin
                        load_out          = 1'b1;
                        n_out.status      = enq_full ? ST_DROPPED : ST_ENQUEUED;
                        n_out.queue_class = i_cmd.cls;
                        n_out.out_tag     = '0;
                        n_out.out_room    = '0;
                    end else if (nonempty == '0) begin
                        load_out          = 1'b1;
                        n_out.status      = ST_EMPTY;
                        n_out.queue_class = CLASS_URGENT;
                        n_out.out_tag     = '0;
                        n_out.out_room    = '0;
                    end else begin
                        n_rd_cls = sel_cls;
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                load_out          = 1'b1;
                n_out.status      = ST_SERVED;
                n_out.queue_class = r_rd_cls;
                n_out.out_tag     = sel_data[ENTRY_W-1:ROOM_W];
                n_out.out_room    = sel_data[ROOM_W-1:0];
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && !i_out_ready);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_tail[c]  <= '0;
                r_count[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= n_head[c];
                r_tail[c]  <= n_tail[c];
                r_count[c] <= n_count[c];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_cls <= n_rd_cls;
        r_out    <= n_out;
    end

    // one ring store per class
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_store
        tcpq_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (push_en[g]),
            .i_wr_addr (r_tail[g]),
            .i_wr_data ({i_cmd.tag, i_cmd.room}),
            .i_rd_en   (pop_en[g]),
            .i_rd_addr (r_head[g]),
            .o_rd_data (rd_data[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/tcpq_checker.sv =====
// port-level checker for the three-class priority queue, bound to the top level
module tcpq_checker
    import tcpq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic [7:0] r_pending;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    // requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 8'd0;
        end else begin
            r_pending <= r_pending + {7'd0, in_xfer} - {7'd0, out_xfer};
        end
    end

    // a result only ever answers an accepted request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 8'd0)
        else $error("result without pending request");

    // a stalled result holds its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // only a served result carries tag and room
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_SERVED
        |-> o_out_data.out_tag == '0 && o_out_data.out_room == '0)
        else $error("tag or room set on non-served result");

    // empty serve reports the urgent class, others never the unused code
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.queue_class != 2'd3 &&
        (o_out_data.status != ST_EMPTY || o_out_data.queue_class == CLASS_URGENT))
        else $error("bad class on result");

endmodule

bind three_class_priority_queue_core tcpq_checker u_tcpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
